// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gbc_pkg.sv =====
// ---------------------------------------------------------------------------
// gbc_pkg
// Types and constants of the 3x3 grid blur block.
// ---------------------------------------------------------------------------
package gbc_pkg;

  // Payload widths.
  localparam int HEIGHT_W   = 24;
  localparam int COORD_W    = 10;
  localparam int GRID_CFG_W = 11;

  // Vertical 1-2-1 column sum and full 3x3 sum widths.
  localparam int VSUM_W = HEIGHT_W + 2;
  localparam int HSUM_W = HEIGHT_W + 4;

  // Rounding bias for the divide by 16.
  localparam int ROUND_BIAS = 8;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [GRID_CFG_W-1:0] GRID_SIZE_RESET = 11'd256;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_GRID_SIZE = 1'b0
  } cfg_reg_t;

endpackage

// ===== rtl/core/gbc_in_if.sv =====
// ---------------------------------------------------------------------------
// gbc_in_if
// Input request channel: one grid height per request.
// ---------------------------------------------------------------------------
interface gbc_in_if import gbc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

// ===== rtl/core/gbc_out_if.sv =====
// ---------------------------------------------------------------------------
// gbc_out_if
// Result request channel: one blurred height with its coordinates.
// ---------------------------------------------------------------------------
interface gbc_out_if import gbc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] blurred_height;
  logic        [COORD_W-1:0]  out_x;
  logic        [COORD_W-1:0]  out_y;
  logic                       run_last;

  modport source (output valid, output blurred_height, output out_x, output out_y,
                  output run_last, input ready);
  modport sink (input valid, input blurred_height, input out_x, input out_y,
                input run_last, output ready);
endinterface

// ===== rtl/core/gaussian_blur_3x3_clamped_grid.sv =====
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_clamped_grid
// 1-2-1 by 1-2-1 blur of a square height grid with replicated borders.
// ---------------------------------------------------------------------------
// Heights enter in raster order. Both previous rows live in one 48-bit wide
// line memory (MAX_GRID entries, registered read), read when a request is
// taken and written back one stage later; an entry is read again only a full
// row later, so no forwarding is needed. A request passes stage 1, the window
// registers and the output register. Most requests give one result; these
// sustain one request per cycle while the output is not stalled. The last
// request of a row and every request of the bottom row past column 0 give two
// results, and the last request of the grid gives four. The single output
// register drains one result per cycle while out_ch.ready is high, so such
// a request holds the input until its results drain. Requests in row 0 or
// column 0 give no result. Row 0 ignores the memory, so it needs no clearing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_blur_3x3_clamped_grid import gbc_pkg::*; #(
  parameter int MAX_GRID = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gbc_in_if.sink                in_ch,
  gbc_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;

  // Flags of a taken request, decided from the grid counters.
  typedef struct packed {
    logic emit;
    logic lastcol;
    logic lastrow;
    logic xone;
    logic row0;
  } item_flags_t;

  // Configuration.
  logic [GRID_CFG_W-1:0] grid_size_r, grid_size_nxt;
  logic [CW-1:0]         last_c;
  logic                  cfg_hit, cfg_wr;

  // Grid counters.
  logic [CW-1:0] x_r, x_nxt, y_r, y_nxt;

  // Stage 1: taken request waiting for its line memory data.
  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [HEIGHT_W-1:0] s1_cur_r;
  logic [CW-1:0]              s1_x_r, s1_y_r;
  item_flags_t                s1_flags_r, in_flags;
  logic [2*HEIGHT_W-1:0]      line_mem [MAX_GRID];
  logic [2*HEIGHT_W-1:0]      mem_q_r;
  logic signed [HEIGHT_W-1:0] up, mid;
  logic signed [VSUM_W-1:0]   va_new, vb_new;

  // Column sums of the window: rows 0-1-2 (va) and rows 1-2-2 (vb).
  logic signed [VSUM_W-1:0] va_r [3];
  logic signed [VSUM_W-1:0] vb_r [3];

  // Result job of the request whose columns sit in va_r / vb_r.
  logic [2:0]    job_left_r, job_left_nxt;
  logic [1:0]    job_k_r, job_k_nxt;
  logic [CW-1:0] job_x_r, job_y_r;
  logic          job_lastcol_r, job_xone_r;
  logic [1:0]    sel;
  logic          row_b, col_last;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [HEIGHT_W-1:0] out_height_r;
  logic [CW-1:0]              out_x_r, out_y_r, res_x, res_y;
  logic                       out_last_r;
  logic signed [VSUM_W-1:0]   col_l, col_m, col_r;
  logic signed [HSUM_W-1:0]   hsum;

  // Handshake terms.
  logic in_fire, out_free, emit_fire, job_done, s1_adv;

  // Configuration port: one register, read back as written.
  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_GRID_SIZE: cfg_hit = (paddr[1:0] == 2'b00);
      default:       cfg_hit = 1'b0;
    endcase
    cfg_wr        = psel && penable && pwrite && cfg_hit;
    grid_size_nxt = cfg_wr ? pwdata[GRID_CFG_W-1:0] : grid_size_r;
    pready        = 1'b1;
    prdata        = cfg_hit ? APB_DATA_W'(grid_size_r) : '0;
  end

  // Last row and column index of the clamped grid size.
  always_comb begin
    if (grid_size_r < GRID_CFG_W'(2)) begin
      last_c = CW'(1);
    end else if (32'(grid_size_r) > MAX_GRID) begin
      last_c = CW'(MAX_GRID - 1);
    end else begin
      last_c = CW'(grid_size_r - GRID_CFG_W'(1));
    end
  end

  // Handshake between the stages.
  always_comb begin
    out_free    = !out_valid_r || out_ch.ready;
    emit_fire   = (job_left_r != 3'd0) && out_free;
    job_done    = (job_left_r == 3'd0) || (emit_fire && job_left_r == 3'd1);
    s1_adv      = s1_valid_r && job_done;
    in_ch.ready = !s1_valid_r || s1_adv;
    in_fire     = in_ch.valid && in_ch.ready;
  end

  // Request flags and raster counter update.
  always_comb begin
    in_flags.emit    = (x_r != '0) && (y_r != '0);
    in_flags.lastcol = (x_r == last_c);
    in_flags.lastrow = (y_r == last_c);
    in_flags.xone    = (x_r == CW'(1));
    in_flags.row0    = (y_r == '0);
    x_nxt = x_r;
    y_nxt = y_r;
    if (cfg_wr) begin
      x_nxt = '0;
      y_nxt = '0;
    end else if (in_fire) begin
      if (in_flags.lastcol) begin
        x_nxt = '0;
        y_nxt = in_flags.lastrow ? '0 : y_r + CW'(1);
      end else begin
        x_nxt = x_r + CW'(1);
      end
    end
    s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);
  end

  // Stage 1: new window column from the line memory and the request.
  always_comb begin
    up     = s1_flags_r.row0 ? s1_cur_r : mem_q_r[2*HEIGHT_W-1:HEIGHT_W];
    mid    = s1_flags_r.row0 ? s1_cur_r : mem_q_r[HEIGHT_W-1:0];
    va_new = VSUM_W'(up) + (VSUM_W'(mid) <<< 1) + VSUM_W'(s1_cur_r);
    vb_new = VSUM_W'(mid) + (VSUM_W'(s1_cur_r) <<< 1) + VSUM_W'(s1_cur_r);
  end

  // Job sequencing: main point, last column, then the same for the last row.
  always_comb begin
    sel      = job_lastcol_r ? job_k_r : {job_k_r[0], 1'b0};
    row_b    = sel[1];
    col_last = sel[0];
    job_left_nxt = job_left_r;
    job_k_nxt    = job_k_r;
    if (s1_adv) begin
      job_k_nxt = 2'd0;
      if (s1_flags_r.emit) begin
        job_left_nxt = {s1_flags_r.lastcol && s1_flags_r.lastrow,
                        s1_flags_r.lastcol ^ s1_flags_r.lastrow,
                        !(s1_flags_r.lastcol || s1_flags_r.lastrow)};
      end else begin
        job_left_nxt = 3'd0;
      end
    end else if (emit_fire) begin
      job_left_nxt = job_left_r - 3'd1;
      job_k_nxt    = job_k_r + 2'd1;
    end
  end

  // Horizontal 1-2-1 over the selected columns, rounded half up.
  always_comb begin
    if (row_b) begin
      col_l = (col_last || job_xone_r) ? vb_r[1] : vb_r[0];
      col_m = col_last ? vb_r[2] : vb_r[1];
      col_r = vb_r[2];
    end else begin
      col_l = (col_last || job_xone_r) ? va_r[1] : va_r[0];
      col_m = col_last ? va_r[2] : va_r[1];
      col_r = va_r[2];
    end
    hsum  = HSUM_W'(col_l) + (HSUM_W'(col_m) <<< 1) + HSUM_W'(col_r)
            + HSUM_W'(ROUND_BIAS);
    res_x = col_last ? job_x_r : job_x_r - CW'(1);
    res_y = row_b ? job_y_r : job_y_r - CW'(1);
    out_valid_nxt = emit_fire || (out_valid_r && !out_ch.ready);
  end

  // Line memory: rows y-2 and y-1 side by side.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_x_r] <= {mid, s1_cur_r};
    end
    if (in_fire) begin
      mem_q_r <= line_mem[x_r];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RESET;
      x_r         <= '0;
      y_r         <= '0;
      s1_valid_r  <= 1'b0;
      job_left_r  <= 3'd0;
      job_k_r     <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        va_r[i] <= '0;
        vb_r[i] <= '0;
      end
    end else begin
      grid_size_r <= grid_size_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      s1_valid_r  <= s1_valid_nxt;
      job_left_r  <= job_left_nxt;
      job_k_r     <= job_k_nxt;
      out_valid_r <= out_valid_nxt;
      // Window shift by one column.
      if (s1_adv) begin
        va_r[0] <= va_r[1];
        va_r[1] <= va_r[2];
        va_r[2] <= va_new;
        vb_r[0] <= vb_r[1];
        vb_r[1] <= vb_r[2];
        vb_r[2] <= vb_new;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r   <= in_ch.height;
      s1_x_r     <= x_r;
      s1_y_r     <= y_r;
      s1_flags_r <= in_flags;
    end
    if (s1_adv) begin
      job_x_r       <= s1_x_r;
      job_y_r       <= s1_y_r;
      job_lastcol_r <= s1_flags_r.lastcol;
      job_xone_r    <= s1_flags_r.xone;
    end
    if (emit_fire) begin
      out_height_r <= hsum[HSUM_W-1:4];
      out_x_r      <= res_x;
      out_y_r      <= res_y;
      out_last_r   <= (job_left_r == 3'd1);
    end
  end

  // Result port.
  always_comb begin
    out_ch.valid          = out_valid_r;
    out_ch.blurred_height = out_height_r;
    out_ch.out_x          = COORD_W'(out_x_r);
    out_ch.out_y          = COORD_W'(out_y_r);
    out_ch.run_last       = out_last_r;
  end

  // A job never holds more than four results.
  `ASSERT_ALWAYS(a_job_bound, job_left_r <= 3'd4, "result job count above four")
  // The write-back and a new read never touch the same line entry at once.
  `ASSERT_IMPLIES(a_mem_no_clash, s1_adv && in_fire, s1_x_r != x_r,
                  "line memory read and write at the same entry")
  // A result always names a point inside the grid.
  `ASSERT_IMPLIES(a_out_in_grid, out_valid_r, (out_x_r <= last_c) && (out_y_r <= last_c),
                  "result coordinates outside the grid")

endmodule
